// ===== hw/rtl/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

  // Default number of entries in the code store.
  localparam int SYMBOL_COUNT_DEF    = 256;
  // Default longest code word in bits.
  localparam int MAX_CODE_LENGTH_DEF = 32;
  // Entries in the queue between the front and the back part.
  localparam int QUEUE_DEPTH         = 2;

  // Fixed field widths of the input and result channels.
  localparam int REQ_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int BITS_IN_W = 32;
  localparam int LEN_IN_W = 6;
  localparam int BYTE_W   = 8;
  // Wide enough for the four bytes one code can complete.
  localparam int NBYTE_W  = 3;
  // Bit position within the pending byte.
  localparam int POS_W    = 3;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  // Queue status seen by the side that pushes and the side that pops.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hcbp_front.sv =====
// Front part: code store, request decode and lookup stage.
`default_nettype none
module hcbp_front #(
  parameter int SYMBOL_COUNT    = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEF,
  parameter int LEN_W           = $clog2(MAX_CODE_LENGTH + 1),
  parameter int ENTRY_W         = 1 + MAX_CODE_LENGTH + LEN_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hcbp_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [hcbp_pkg::SYM_IN_W-1:0]     in_symbol,
  input  wire logic [hcbp_pkg::BITS_IN_W-1:0]    in_code_bits,
  input  wire logic [hcbp_pkg::LEN_IN_W-1:0]     in_code_length,
  input  wire hcbp_pkg::q_stat_t                 q_stat,
  output logic                                   q_push,
  output logic [ENTRY_W-1:0]                     q_wdata
);

  localparam int SYM_W = $clog2(SYMBOL_COUNT);
  localparam int MEM_W = MAX_CODE_LENGTH + LEN_W;

  logic [MEM_W-1:0] code_mem [SYMBOL_COUNT];
  logic [MEM_W-1:0] rd_data_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_flush_r, s1_flush_nxt;

  logic                       accept;
  logic                       sym_ok;
  logic [SYM_W-1:0]           idx;
  logic                       do_load;
  logic                       do_encode;
  logic                       do_flush;
  logic [hcbp_pkg::LEN_IN_W-1:0] len_clamp;
  logic [LEN_W-1:0]           ld_len;
  logic [MAX_CODE_LENGTH-1:0] ld_mask;
  logic [MAX_CODE_LENGTH-1:0] ld_bits;

  assign in_stall = s1_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_valid_r && !q_stat.full;
  assign q_wdata  = {s1_flush_r, rd_data_r};

  assign sym_ok = ({1'b0, in_symbol} < (hcbp_pkg::SYM_IN_W + 1)'(SYMBOL_COUNT));
  assign idx    = in_symbol[SYM_W-1:0];

  always_comb begin
    do_load   = 1'b0;
    do_encode = 1'b0;
    do_flush  = 1'b0;
    unique case (in_req_type)
      hcbp_pkg::REQ_LOAD:   do_load   = accept && sym_ok;
      hcbp_pkg::REQ_ENCODE: do_encode = accept && sym_ok;
      hcbp_pkg::REQ_FLUSH:  do_flush  = accept;
      default: ;
    endcase
  end

  // Lengths beyond the longest code are clamped; bits above the length are dropped.
  always_comb begin
    if (in_code_length > hcbp_pkg::LEN_IN_W'(MAX_CODE_LENGTH)) begin
      len_clamp = hcbp_pkg::LEN_IN_W'(MAX_CODE_LENGTH);
    end else begin
      len_clamp = in_code_length;
    end
    ld_len = len_clamp[LEN_W-1:0];
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      ld_mask[i] = (i < int'(ld_len));
    end
    ld_bits = in_code_bits[MAX_CODE_LENGTH-1:0] & ld_mask;
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= {ld_bits, ld_len};
    end
    if (do_encode) begin
      rd_data_r <= code_mem[idx];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
    if (do_encode || do_flush) begin
      s1_valid_nxt = 1'b1;
      s1_flush_nxt = do_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hcbp_queue.sv =====
// Short queue of looked-up requests between the front and the back part.
`default_nettype none
module hcbp_queue #(
  parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output hcbp_pkg::q_stat_t     stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat    = '{full: (count_r == CNT_W'(DEPTH)), empty: (count_r == '0)};
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hcbp_back.sv =====
// Back part: bit packing into bytes and the output register.
`default_nettype none
module hcbp_back #(
  parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEF,
  parameter int LEN_W           = $clog2(MAX_CODE_LENGTH + 1),
  parameter int ENTRY_W         = 1 + MAX_CODE_LENGTH + LEN_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hcbp_pkg::q_stat_t              q_stat,
  input  wire logic [ENTRY_W-1:0]             q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last_of_run
);

  localparam int BW    = hcbp_pkg::BYTE_W;
  localparam int WW    = MAX_CODE_LENGTH + BW;
  localparam int SUM_W = (LEN_W + 1 > 4) ? LEN_W + 1 : 4;
  localparam int NW    = hcbp_pkg::NBYTE_W;
  localparam int PW    = hcbp_pkg::POS_W;

  logic                 busy_r, busy_nxt;
  logic [WW-1:0]        word_r, word_nxt;
  logic [NW-1:0]        left_r, left_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic [BW-1:0]        pend_byte_r, pend_byte_nxt;
  logic [PW-1:0]        pend_cnt_r, pend_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BW-1:0]        out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                       e_flush;
  logic [MAX_CODE_LENGTH-1:0] e_bits;
  logic [LEN_W-1:0]           e_len;
  logic [LEN_W-1:0]           shamt;
  logic [MAX_CODE_LENGTH-1:0] code_la;
  logic [WW-1:0]              new_word;
  logic [SUM_W-1:0]           total;
  logic [NW-1:0]              new_nb;
  logic [PW-1:0]              new_rem;
  logic                       out_free;

  assign {e_flush, e_bits, e_len} = q_rdata;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !busy_r && !q_stat.empty;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  // Merge the pending bits with the code, both left-aligned in one word.
  always_comb begin
    shamt   = LEN_W'(MAX_CODE_LENGTH) - e_len;
    code_la = e_bits << shamt;
    total   = SUM_W'(pend_cnt_r) + SUM_W'(e_len);
    if (e_flush) begin
      new_word = {pend_byte_r, MAX_CODE_LENGTH'(0)};
      new_nb   = (pend_cnt_r != '0) ? NW'(1) : '0;
      new_rem  = '0;
    end else begin
      new_word = {pend_byte_r, MAX_CODE_LENGTH'(0)} | ({code_la, BW'(0)} >> pend_cnt_r);
      new_nb   = NW'(total >> 3);
      new_rem  = total[PW-1:0];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    word_nxt      = word_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    pend_byte_nxt = pend_byte_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (busy_r) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = word_r[WW-1 -: BW];
        out_last_nxt  = (left_r == NW'(1));
        word_nxt      = word_r << BW;
        left_nxt      = left_r - 1'b1;
        if (left_r == NW'(1)) begin
          busy_nxt      = 1'b0;
          pend_byte_nxt = word_r[WW-BW-1 -: BW];
          pend_cnt_nxt  = rem_r;
        end
      end
    end else if (q_pop) begin
      if (new_nb == '0) begin
        pend_byte_nxt = new_word[WW-1 -: BW];
        pend_cnt_nxt  = new_rem;
      end else if (out_free) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = new_word[WW-1 -: BW];
        out_last_nxt  = (new_nb == NW'(1));
        if (new_nb == NW'(1)) begin
          pend_byte_nxt = new_word[WW-BW-1 -: BW];
          pend_cnt_nxt  = new_rem;
        end else begin
          busy_nxt = 1'b1;
          word_nxt = new_word << BW;
          left_nxt = new_nb - 1'b1;
          rem_nxt  = new_rem;
        end
      end else begin
        busy_nxt = 1'b1;
        word_nxt = new_word;
        left_nxt = new_nb;
        rem_nxt  = new_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    left_r     <= left_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_byte_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// Top level of the table-driven Huffman encoder with MSB-first byte packing.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   req_type, symbol, code_bits, code_length
//   out_     output     out_valid/out_stall out_byte, last_of_run
//
// The front part takes one transaction per cycle while in_stall is low. A load
// writes the code store at once; an encode reads it into a lookup register, and
// the looked-up entry then enters a two-entry queue. The back part packs one
// queued request at a time and emits at most one byte per cycle; an encode
// that completes several bytes holds it until the last one is emitted. With
// nothing queued ahead, the first byte of a transaction passes through the
// lookup register and the queue before the output register presents it. Reset
// clears the pending bits and all control state at once; there is no clearing
// pass, and the code store holds nothing valid until loaded. Stalls on the
// result side fill the queue and then raise in_stall; loads are held back along
// with everything else.
`default_nettype none
module huffman_code_bit_packer_core #(
  parameter int SYMBOL_COUNT    = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [hcbp_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [hcbp_pkg::SYM_IN_W-1:0]  in_symbol,
  input  wire logic [hcbp_pkg::BITS_IN_W-1:0] in_code_bits,
  input  wire logic [hcbp_pkg::LEN_IN_W-1:0]  in_code_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last_of_run
);

  // Width of a stored code length, and of one queue entry: a flush flag,
  // the code word and its length.
  localparam int LEN_W   = $clog2(MAX_CODE_LENGTH + 1);
  localparam int ENTRY_W = 1 + MAX_CODE_LENGTH + LEN_W;

  hcbp_pkg::q_stat_t    q_stat;
  logic                 q_push;
  logic                 q_pop;
  logic [ENTRY_W-1:0]   q_wdata;
  logic [ENTRY_W-1:0]   q_rdata;

  // Front part: decodes each transaction, updates the code store on a load
  // and looks up the code of an encoded symbol.
  hcbp_front #(
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .LEN_W           (LEN_W),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // The queue lets the front keep accepting while the back emits bytes.
  hcbp_queue #(
    .DEPTH (hcbp_pkg::QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back part: appends codes to the pending byte and emits full bytes (and, on a
  // flush, the padded pending byte), the last one of each transaction marked.
  hcbp_back #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .LEN_W           (LEN_W),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Huffman code bit packer core.
`timescale 1ns / 100ps
module testbench;

  // The request type that no operation uses; the block must ignore it.
  localparam logic [hcbp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Code length that the block keeps at most.
  localparam int LONGEST_CODE = hcbp_pkg::MAX_CODE_LENGTH_DEF;
  // Cycles that pass after the last byte so that stray output is caught.
  localparam int SETTLE_CYCLES = 20;
  // Mismatches that are printed in detail; later ones are only counted.
  localparam int SHOWN_LIMIT = 10;

  // One packed byte as the result channel carries it.
  typedef struct packed {
    logic [hcbp_pkg::BYTE_W-1:0] value;
    logic                        last;
  } coded_byte_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [hcbp_pkg::REQ_W-1:0]     in_req_type;
  logic [hcbp_pkg::SYM_IN_W-1:0]  in_symbol;
  logic [hcbp_pkg::BITS_IN_W-1:0] in_code_bits;
  logic [hcbp_pkg::LEN_IN_W-1:0]  in_code_length;
  logic                           out_valid;
  logic                           out_stall;
  logic [hcbp_pkg::BYTE_W-1:0]    out_byte;
  logic                           out_last_of_run;

  // Our own copy of the code table and of the partly filled byte.
  logic [hcbp_pkg::BITS_IN_W-1:0] table_code [hcbp_pkg::SYMBOL_COUNT_DEF];
  logic [hcbp_pkg::LEN_IN_W-1:0]  table_len [hcbp_pkg::SYMBOL_COUNT_DEF];
  bit                             table_loaded [hcbp_pkg::SYMBOL_COUNT_DEF];
  logic [hcbp_pkg::SYM_IN_W-1:0]  loaded_symbols[$];
  logic [hcbp_pkg::BYTE_W-1:0]    partial_byte;
  int                             partial_bits;

  // Bytes that the block still owes, oldest first.
  coded_byte_t          expected_bytes[$];

  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   error_count;
  int                   shown_count;

  huffman_code_bit_packer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run ends here if the block hangs or never delivers a byte that it owes.
  initial begin
    #400_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Works out the bytes that one accepted transaction must produce and queues them.
  // A load only updates the table. An encode shifts the code in, most significant
  // bit first, and every byte that fills is owed. A flush owes the partial byte
  // when it holds any bits. The last byte owed by a transaction carries the flag.
  task automatic pack_request(input logic [hcbp_pkg::REQ_W-1:0] req,
                              input logic [hcbp_pkg::SYM_IN_W-1:0] sym,
                              input logic [hcbp_pkg::BITS_IN_W-1:0] bits,
                              input logic [hcbp_pkg::LEN_IN_W-1:0] len);
    logic [hcbp_pkg::LEN_IN_W-1:0]  kept_len;
    logic [63:0]                    mask;
    logic [hcbp_pkg::BITS_IN_W-1:0] code;
    coded_byte_t                    fresh[$];
    case (req)
      hcbp_pkg::REQ_LOAD: begin
        // Lengths past the longest code are clipped, and bits above the length dropped.
        kept_len = (len > LONGEST_CODE) ? hcbp_pkg::LEN_IN_W'(LONGEST_CODE) : len;
        mask = (64'd1 << kept_len) - 64'd1;
        table_code[sym] = bits & mask[hcbp_pkg::BITS_IN_W-1:0];
        table_len[sym] = kept_len;
        if (!table_loaded[sym]) begin
          table_loaded[sym] = 1'b1;
          loaded_symbols.push_back(sym);
        end
      end
      hcbp_pkg::REQ_ENCODE: begin
        code = table_code[sym];
        for (int i = int'(table_len[sym]); i > 0; i--) begin
          partial_byte[7 - partial_bits] = code[i-1];
          partial_bits++;
          if (partial_bits == 8) begin
            fresh.push_back('{value: partial_byte, last: 1'b0});
            partial_byte = '0;
            partial_bits = 0;
          end
        end
      end
      hcbp_pkg::REQ_FLUSH: begin
        if (partial_bits != 0) begin
          fresh.push_back('{value: partial_byte, last: 1'b0});
          partial_byte = '0;
          partial_bits = 0;
        end
      end
      default: begin
        // The unused request type changes nothing.
      end
    endcase
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[k]) expected_bytes.push_back(fresh[k]);
  endtask

  // Offers one transaction after a random idle gap and waits until it is taken.
  // Inputs change only at the falling edge; acceptance is judged at the rising edge.
  task automatic send_request(input logic [hcbp_pkg::REQ_W-1:0] req,
                              input logic [hcbp_pkg::SYM_IN_W-1:0] sym,
                              input logic [hcbp_pkg::BITS_IN_W-1:0] bits,
                              input logic [hcbp_pkg::LEN_IN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_req_type = req;
    in_symbol = sym;
    in_code_bits = bits;
    in_code_length = len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_request(req, sym, bits, len);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic note_failure(input string what);
    error_count++;
    if (shown_count < SHOWN_LIMIT) begin
      shown_count++;
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // The receiver holds off at random; the stall only changes at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every byte the block hands over is compared with the oldest byte still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b", out_byte, out_last_of_run));
      end else begin
        if (out_byte !== expected_bytes[0].value)
          note_failure($sformatf("byte expected %02h actual %02h",
                                 expected_bytes[0].value, out_byte));
        if (out_last_of_run !== expected_bytes[0].last)
          note_failure($sformatf("last_of_run expected %0b actual %0b (byte %02h)",
                                 expected_bytes[0].last, out_last_of_run, out_byte));
        void'(expected_bytes.pop_front());
      end
    end
  end

  // Loads at the edges of the fields: a full-width code of all ones, a one-bit code,
  // a length past the longest code, stray bits above the length, a zero-length code,
  // and the largest length the field can carry.
  task automatic test_load_extremes();
    send_request(hcbp_pkg::REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_request(hcbp_pkg::REQ_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_request(hcbp_pkg::REQ_LOAD, 8'h55, 32'hA5A5_A5A5, 6'd40);
    send_request(hcbp_pkg::REQ_LOAD, 8'hAA, 32'hFFFF_FFF3, 6'd3);
    send_request(hcbp_pkg::REQ_LOAD, 8'h0F, 32'hDEAD_BEEF, 6'd0);
    send_request(hcbp_pkg::REQ_LOAD, 8'hF0, 32'h1234_5678, 6'd63);
  endtask

  // Long codes that fill four bytes at once, both from an empty byte and on top of
  // one and of seven pending bits.
  task automatic test_long_codes();
    send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hF0, 32'hFFFF_FFFF, 6'd63);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'h55, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
  endtask

  // Flushes with nothing pending and a zero-length code must produce nothing;
  // a flush of three bits pads with zeros.
  task automatic test_flush_and_empty();
    send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'h0F, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  // The unused request type with every field at ones must leave the state alone.
  task automatic test_unused_request();
    send_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_request(hcbp_pkg::REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  // A random stream that is mostly encodes of loaded symbols, with table updates,
  // flushes and some ignored noise mixed in. Only symbols that have been loaded are
  // ever encoded, since an unloaded table entry holds nothing defined.
  task automatic test_random_stream(input int items);
    int                            done;
    int                            pick;
    logic [hcbp_pkg::LEN_IN_W-1:0] len;
    logic [hcbp_pkg::SYM_IN_W-1:0] sym;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        // Mostly short codes, some long ones, and a few lengths anywhere in the field.
        case ($urandom_range(9))
          0: len = hcbp_pkg::LEN_IN_W'($urandom_range(63));
          1, 2: len = hcbp_pkg::LEN_IN_W'($urandom_range(32, 13));
          default: len = hcbp_pkg::LEN_IN_W'($urandom_range(12, 1));
        endcase
        send_request(hcbp_pkg::REQ_LOAD, hcbp_pkg::SYM_IN_W'($urandom_range(255)),
                     $urandom, len);
      end else if (pick < 80) begin
        sym = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
        send_request(hcbp_pkg::REQ_ENCODE, sym, $urandom,
                     hcbp_pkg::LEN_IN_W'($urandom_range(63)));
      end else if (pick < 92) begin
        send_request(hcbp_pkg::REQ_FLUSH, hcbp_pkg::SYM_IN_W'($urandom_range(255)),
                     $urandom, hcbp_pkg::LEN_IN_W'($urandom_range(63)));
      end else begin
        send_request(REQ_UNUSED, hcbp_pkg::SYM_IN_W'($urandom_range(255)), $urandom,
                     hcbp_pkg::LEN_IN_W'($urandom_range(63)));
      end
      done++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = hcbp_pkg::REQ_LOAD;
    in_symbol = '0;
    in_code_bits = '0;
    in_code_length = '0;
    partial_byte = '0;
    partial_bits = 0;
    error_count = 0;
    shown_count = 0;
    send_idle_pct = 34;
    recv_idle_pct = 79;
    foreach (table_loaded[s]) table_loaded[s] = 1'b0;

    // Synchronous reset, released away from the rising edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_load_extremes();
    test_long_codes();
    test_flush_and_empty();
    test_unused_request();

    // The random part runs first with a busy receiver, then with a slow sender,
    // and last with no idling on either side.
    test_random_stream(32);
    send_idle_pct = 79;
    recv_idle_pct = 34;
    test_random_stream(32);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(32);

    // Wait for every owed byte, then a little longer to catch anything extra.
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_front.sv
hw/rtl/hcbp_queue.sv
hw/rtl/hcbp_back.sv
hw/rtl/huffman_code_bit_packer_core.sv
tb/testbench.sv
